### hw/rtl/pop_pkg.sv
// pop_pkg: constants, codes and shared types of the patch overlap average core.
// No dependencies; imported by pop_div, pop_store, patch_overlap_average_core, pop_checker and tb_top.
package pop_pkg;

  localparam int MAX_PATCHES   = 256;
  localparam int MAX_PATCH_LEN = 64;
  localparam int SAMPLE_BITS   = 16;

  localparam int PIDX_W = $clog2(MAX_PATCHES);
  localparam int OFF_W  = $clog2(MAX_PATCH_LEN);
  localparam int ADDR_W = PIDX_W + OFF_W;
  localparam int HOP_W  = OFF_W + 1;
  localparam int CNT_W  = OFF_W + 1;
  localparam int NP_W   = PIDX_W + 1;
  localparam int POS_W  = 16;
  localparam int I_W    = POS_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + OFF_W;
  localparam int DIV_W  = (SUM_W > I_W) ? SUM_W : I_W;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int PROD_W = PIDX_W + HOP_W;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 16;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CIDX_W-1:0] REG_HOP         = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PATCH_LEN   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_NUM_PATCHES = 3'd2;
  localparam logic [CIDX_W-1:0] REG_START_POS   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_OUT_COUNT   = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [HOP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/patch_overlap_average_core.sv
// patch_overlap_average_core: rebuilds a long signal from overlapping patches.
// Depends on pop_pkg, pop_div and pop_store.
//
// A load word writes one patch sample. A query word makes up to three passes
// through one shared bit-serial divider (position / hop, patch_len / hop,
// sum / count) with one memory read per covering patch; a query that ends in
// error skips the reads and the last division. The input stalls while a query
// is in work; a finished result waits in the output register without blocking
// loads.
module patch_overlap_average_core
  import pop_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [PIDX_W-1:0]             patch_index,
  input  logic [OFF_W-1:0]              offset,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [POS_W-1:0]              position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic [CNT_W-1:0]              cover_count,
  output logic                          error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CIDX_W-1:0]             cfg_index,
  input  logic [CDAT_W-1:0]             cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIVQ  = 10'b0000000010,
    S_DIVN  = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_CHECK = 10'b0000010000,
    S_READ  = 10'b0000100000,
    S_DRAIN = 10'b0001000000,
    S_ABS   = 10'b0010000000,
    S_DIVA  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  logic [HOP_W-1:0] hop;
  logic [HOP_W-1:0] patch_len;
  logic [NP_W-1:0]  num_patches;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] out_count;

  logic [HOP_W-1:0]  hop_c;
  logic [HOP_W-1:0]  plen_c;
  logic [PIDX_W-1:0] lastp;

  logic [POS_W-1:0]  pos_q;
  logic [I_W-1:0]    ipos;
  logic [I_W-1:0]    ipos_next;
  logic [I_W-1:0]    q;
  logic [PIDX_W-1:0] first;
  logic [PIDX_W-1:0] last;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  logic [I_W-1:0]    diff;
  logic              err_q;

  logic [PIDX_W-1:0] k;
  logic [HOP_W-1:0]  o;
  logic [CNT_W-1:0]  remain;
  logic              rd_pend;
  logic signed [SUM_W-1:0] sum;
  logic              neg;

  logic [HOP_W-1:0]        nseg;
  logic signed [I_W+1:0]   aux;
  logic [PIDX_W-1:0]       first_next;
  logic [PIDX_W-1:0]       last_next;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        avg_full;

  logic signed [SAMPLE_BITS-1:0] res_avg;
  logic [CNT_W-1:0]              res_cnt;
  logic                          res_err;

  logic                   in_acc;
  logic                   st_wr_en;
  logic [ADDR_W-1:0]      st_rd_addr;
  logic [SAMPLE_BITS-1:0] st_rd_data;
  div_req_t               dreq;
  div_rsp_t               drsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign st_wr_en  = in_acc && (action == ACT_LOAD);
  assign st_rd_addr = {k, o[OFF_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      hop         <= HOP_W'(1);
      patch_len   <= HOP_W'(MAX_PATCH_LEN);
      num_patches <= NP_W'(MAX_PATCHES);
      start_pos   <= '0;
      out_count   <= POS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOP:         hop         <= cfg_data[HOP_W-1:0];
        REG_PATCH_LEN:   patch_len   <= cfg_data[HOP_W-1:0];
        REG_NUM_PATCHES: num_patches <= cfg_data[NP_W-1:0];
        REG_START_POS:   start_pos   <= cfg_data[POS_W-1:0];
        REG_OUT_COUNT:   out_count   <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their usable ranges
  always_comb begin
    logic [NP_W-1:0] np_c;
    if (hop == '0) hop_c = HOP_W'(1);
    else if (hop > HOP_W'(MAX_PATCH_LEN)) hop_c = HOP_W'(MAX_PATCH_LEN);
    else hop_c = hop;
    if (patch_len == '0) plen_c = HOP_W'(1);
    else if (patch_len > HOP_W'(MAX_PATCH_LEN)) plen_c = HOP_W'(MAX_PATCH_LEN);
    else plen_c = patch_len;
    if (num_patches == '0) np_c = NP_W'(1);
    else if (num_patches > NP_W'(MAX_PATCHES)) np_c = NP_W'(MAX_PATCHES);
    else np_c = num_patches;
    lastp = PIDX_W'(np_c - 1'b1);
  end

  assign ipos_next = {1'b0, start_pos} + {1'b0, position};
  assign nseg      = drsp.quotient[HOP_W-1:0];
  assign aux       = $signed({2'b00, q}) + $signed((I_W+2)'(1))
                     - $signed({{(I_W+2-HOP_W){1'b0}}, nseg});
  assign sum_mag   = (sum < 0) ? SUM_W'(-sum) : SUM_W'(sum);
  assign avg_full  = neg ? SUM_W'(-drsp.quotient[SUM_W-1:0])
                         : drsp.quotient[SUM_W-1:0];

  always_comb begin
    if (q > I_W'(lastp)) last_next = lastp;
    else last_next = q[PIDX_W-1:0];
    if (aux < 0) first_next = '0;
    else if (aux > $signed({{(I_W+2-PIDX_W){1'b0}}, lastp})) first_next = lastp;
    else first_next = aux[PIDX_W-1:0];
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = hop_c;
    case (state)
      S_IDLE: begin
        dreq.start    = in_acc && (action == ACT_QUERY);
        dreq.dividend = DIV_W'(ipos_next);
      end
      S_DIVQ: begin
        dreq.start    = drsp.done;
        dreq.dividend = DIV_W'(plen_c);
      end
      S_ABS: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(sum_mag);
        dreq.divisor  = cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && action == ACT_QUERY) begin
            state <= S_DIVQ;
          end
        end
        S_DIVQ:  if (drsp.done) state <= S_DIVN;
        S_DIVN:  if (drsp.done) state <= S_MUL;
        S_MUL:   state <= S_CHECK;
        S_CHECK: begin
          if (err_q) state <= S_DONE;
          else state <= S_READ;
        end
        S_READ:  if (remain == CNT_W'(1)) state <= S_DRAIN;
        S_DRAIN: state <= S_ABS;
        S_ABS:   state <= S_DIVA;
        S_DIVA:  if (drsp.done) state <= S_DONE;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_q <= position;
      ipos  <= ipos_next;
    end
    if (state == S_DIVQ && drsp.done) begin
      q <= drsp.quotient[I_W-1:0];
    end
    if (state == S_DIVN && drsp.done) begin
      first <= first_next;
      last  <= last_next;
      cnt   <= CNT_W'(last_next - first_next + 1'b1);
    end
    if (state == S_MUL) begin
      prod <= {{(PROD_W-PIDX_W){1'b0}}, first} * {{(PROD_W-HOP_W){1'b0}}, hop_c};
    end
    if (state == S_CHECK) begin
      k      <= first;
      o      <= diff[HOP_W-1:0];
      remain <= cnt;
      sum    <= '0;
      if (err_q) begin
        res_avg <= '0;
        res_cnt <= '0;
        res_err <= 1'b1;
      end
    end
    if (state == S_READ) begin
      k      <= k + 1'b1;
      o      <= o - hop_c;
      remain <= remain - 1'b1;
    end
    if (rd_pend) begin
      sum <= sum + SUM_W'(signed'(st_rd_data));
    end
    if (state == S_ABS) begin
      neg <= sum < 0;
    end
    if (state == S_DIVA && drsp.done) begin
      res_avg <= signed'(avg_full[SAMPLE_BITS-1:0]);
      res_cnt <= cnt;
      res_err <= 1'b0;
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      average     <= res_avg;
      cover_count <= res_cnt;
      error       <= res_err;
    end
  end

  assign diff  = ipos - I_W'(prod);
  assign err_q = (pos_q >= out_count) || (first > last) || (diff >= I_W'(plen_c));

  pop_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  pop_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr ({patch_index, offset}),
    .wr_data (sample_in),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

endmodule

### hw/rtl/pop_div.sv
// pop_div: shared restoring divider, one quotient bit per cycle.
// Depends on pop_pkg (widths, request and response types).
module pop_div
  import pop_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  work;
  logic [HOP_W-1:0]  rem;
  logic [HOP_W-1:0]  dvs;
  logic [DCNT_W-1:0] count;
  logic              busy;
  logic              done;
  logic [HOP_W:0]    trial;
  logic              fits;

  assign trial = {rem, work[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work  <= req.dividend;
      rem   <= '0;
      dvs   <= req.divisor;
      count <= DCNT_W'(DIV_W - 1);
    end else if (busy) begin
      count <= count - 1'b1;
      if (fits) begin
        rem  <= HOP_W'(trial - {1'b0, dvs});
        work <= {work[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= trial[HOP_W-1:0];
        work <= {work[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

### hw/rtl/pop_store.sv
// pop_store: patch sample memory, one write port and one registered read port.
// Depends on pop_pkg (address and sample widths).
module pop_store
  import pop_pkg::*;
(
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic [ADDR_W-1:0]      rd_addr,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] mem [MAX_PATCHES*MAX_PATCH_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### tb/pop_checker.sv
// pop_checker: scoreboard for patch_overlap_average_core. Follows register and
// patch sample writes, predicts every query word and compares result words in order.
// Depends on pop_pkg; instantiated by tb_top beside the core.
module pop_checker
  import pop_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          action,
  input  logic [PIDX_W-1:0]             patch_index,
  input  logic [OFF_W-1:0]              offset,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [POS_W-1:0]              position,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] average,
  input  logic [CNT_W-1:0]              cover_count,
  input  logic                          error,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CIDX_W-1:0]             cfg_index,
  input  logic [CDAT_W-1:0]             cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [CNT_W-1:0]              cover_count;
    logic                          error;
  } overlap_avg_t;

  logic signed [SAMPLE_BITS-1:0] patch_mem [MAX_PATCHES*MAX_PATCH_LEN];
  overlap_avg_t                  averages_due [$];
  logic [HOP_W-1:0]              hop_q;
  logic [HOP_W-1:0]              plen_q;
  logic [NP_W-1:0]               np_q;
  logic [POS_W-1:0]              start_q;
  logic [POS_W-1:0]              count_q;

  function automatic int usable(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic overlap_avg_t average_at(logic [POS_W-1:0] j);
    int           h;
    int           plen;
    int           np;
    int           i;
    int           q;
    int           first;
    int           last;
    int           cnt;
    longint       sum;
    overlap_avg_t r;
    h     = usable(int'(hop_q), MAX_PATCH_LEN);
    plen  = usable(int'(plen_q), MAX_PATCH_LEN);
    np    = usable(int'(np_q), MAX_PATCHES);
    i     = int'(start_q) + int'(j);
    q     = i / h;
    last  = (q < np - 1) ? q : np - 1;
    first = q - plen / h + 1;
    if (first > np - 1) first = np - 1;
    if (first < 0) first = 0;
    r = '0;
    if (j >= count_q || first > last || i - first * h >= plen) begin
      r.error = 1'b1;
      return r;
    end
    sum = 0;
    for (int k = first; k <= last; k++) begin
      sum += patch_mem[k * MAX_PATCH_LEN + i - k * h];
    end
    cnt           = last - first + 1;
    r.average     = SAMPLE_BITS'(sum / cnt);
    r.cover_count = CNT_W'(cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    overlap_avg_t want;
    if (rst) begin
      hop_q   = HOP_W'(1);
      plen_q  = HOP_W'(MAX_PATCH_LEN);
      np_q    = NP_W'(MAX_PATCHES);
      start_q = '0;
      count_q = POS_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOP:         hop_q   = cfg_data[HOP_W-1:0];
          REG_PATCH_LEN:   plen_q  = cfg_data[HOP_W-1:0];
          REG_NUM_PATCHES: np_q    = cfg_data[NP_W-1:0];
          REG_START_POS:   start_q = cfg_data[POS_W-1:0];
          REG_OUT_COUNT:   count_q = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (action == ACT_LOAD) patch_mem[{patch_index, offset}] = sample_in;
        else averages_due.push_back(average_at(position));
      end
      if (out_valid && !out_stall) begin
        if (averages_due.size() == 0) begin
          $error("result word with no query waiting");
          fail_count++;
        end else begin
          want = averages_due.pop_front();
          if (average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, average);
            fail_count++;
          end
          if (cover_count !== want.cover_count) begin
            $error("cover_count: expected %0d, got %0d", want.cover_count, cover_count);
            fail_count++;
          end
          if (error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, error);
            fail_count++;
          end
        end
      end
    end
    pending = averages_due.size();
  end

endmodule

### tb/tb_top.sv
// tb_top: stimulus for patch_overlap_average_core: register settings, patch loads
// and position queries with random idling and one long output hold-off.
// Depends on pop_pkg, the core RTL and pop_checker, which scores the result words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pop_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_FROM   = 900;
  localparam int QUIET_TO     = 1150;
  localparam logic [CIDX_W-1:0] REG_UNUSED_LO = CIDX_W'(REG_OUT_COUNT + 1);
  localparam logic [CIDX_W-1:0] REG_UNUSED_HI = '1;

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic                          action      = ACT_LOAD;
  logic [PIDX_W-1:0]             patch_index = '0;
  logic [OFF_W-1:0]              offset      = '0;
  logic signed [SAMPLE_BITS-1:0] sample_in   = '0;
  logic [POS_W-1:0]              position    = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic signed [SAMPLE_BITS-1:0] average;
  logic [CNT_W-1:0]              cover_count;
  logic                          error;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  logic [CIDX_W-1:0]             cfg_index   = '0;
  logic [CDAT_W-1:0]             cfg_data    = '0;
  int                            fail_count;
  int                            pending;

  int items_sent;
  int cycles;
  bit quiet;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int eff_hop   = 1;
  int eff_plen  = MAX_PATCH_LEN;
  int eff_np    = MAX_PATCHES;
  int cur_start = 0;
  int cur_count = 1;
  bit loaded [MAX_PATCHES][MAX_PATCH_LEN];

  patch_overlap_average_core uut (.*);
  pop_checker chk (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // output side: random stalls, one long hold-off so the core backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 9);
    end
  end

  function automatic int usable(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [CDAT_W-1:0] with_junk(int v, int w);
    logic [CDAT_W-1:0] junk;
    junk = $urandom_range(1) ? ((CDAT_W'($urandom) >> w) << w) : '0;
    return CDAT_W'(v) | junk;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    if (r == 1) return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    return SAMPLE_BITS'($urandom);
  endfunction

  task automatic send_word(input logic act, input logic [PIDX_W-1:0] pidx,
                           input logic [OFF_W-1:0] off,
                           input logic [SAMPLE_BITS-1:0] smp,
                           input logic [POS_W-1:0] pos);
    bit calm;
    calm = items_sent >= QUIET_FROM && items_sent < QUIET_TO;
    quiet <= calm;
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    patch_index <= pidx;
    offset      <= off;
    sample_in   <= smp;
    position    <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (act == ACT_LOAD) loaded[pidx][off] = 1'b1;
  endtask

  task automatic load_sample(input int k, input int o);
    send_word(ACT_LOAD, PIDX_W'(k), OFF_W'(o), pick_sample(), POS_W'($urandom));
  endtask

  // fill every patch sample the query can read, then send it
  task automatic query(input int j);
    int i;
    int k;
    j = j & 32'h0000_FFFF;
    if (j < cur_count) begin
      i = cur_start + j;
      k = i / eff_hop;
      if (k > eff_np - 1) k = eff_np - 1;
      while (k >= 0 && i - k * eff_hop < eff_plen) begin
        if (!loaded[k][i - k * eff_hop]) load_sample(k, i - k * eff_hop);
        k--;
      end
    end
    send_word(ACT_QUERY, PIDX_W'($urandom), OFF_W'($urandom), SAMPLE_BITS'($urandom),
              POS_W'(j));
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HOP:         eff_hop   = usable(int'(val[HOP_W-1:0]), MAX_PATCH_LEN);
      REG_PATCH_LEN:   eff_plen  = usable(int'(val[HOP_W-1:0]), MAX_PATCH_LEN);
      REG_NUM_PATCHES: eff_np    = usable(int'(val[NP_W-1:0]), MAX_PATCHES);
      REG_START_POS:   cur_start = int'(val);
      REG_OUT_COUNT:   cur_count = int'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int h, input int pl, input int np, input int st,
                            input int cnt);
    drain();
    write_reg(REG_HOP, with_junk(h, HOP_W));
    write_reg(REG_PATCH_LEN, with_junk(pl, HOP_W));
    write_reg(REG_NUM_PATCHES, with_junk(np, NP_W));
    write_reg(REG_START_POS, with_junk(st, POS_W));
    if ($urandom_range(3) == 0)
      write_reg(CIDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), CDAT_W'($urandom));
    write_reg(REG_OUT_COUNT, with_junk(cnt, POS_W));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int probes [10];
    int h;
    int pl;
    int np;
    int st;
    int cnt;
    int lim;
    int j0;
    int span;
    int pick;
    int phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // hop 2, length 4, three patches: positions 0..7 covered, 8 up not covered
    set_config(2, 4, 3, 0, 16);
    for (int k = 0; k < 3; k++) begin
      for (int o = 0; o < 4; o++) begin
        send_word(ACT_LOAD, PIDX_W'(k), OFF_W'(o),
                  (k == 0) ? 16'h7FFF : ((k == 1) ? 16'h8000 : SAMPLE_BITS'($urandom)),
                  POS_W'($urandom));
      end
    end
    send_word(ACT_LOAD, '1, '1, SAMPLE_BITS'($urandom), '1);
    probes = '{0, 1, 2, 3, 5, 7, 8, 15, 16, 65535};
    foreach (probes[n]) query(probes[n]);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin h = 1;   pl = 64;  np = 256; st = 0;     cnt = 65535; end
        1: begin h = 127; pl = 0;   np = 0;   st = 65535; cnt = 1;     end
        2: begin h = 0;   pl = 127; np = 511; st = 0;     cnt = 40;    end
        3: begin h = 64;  pl = 64;  np = 256; st = 16000; cnt = 65535; end
        default: begin
          h   = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(64, 1);
          pl  = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(64, 1);
          np  = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(16, 1);
          st  = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(200);
          cnt = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(300, 1);
        end
      endcase
      set_config(h, pl, np, st, cnt);

      lim = (eff_np - 1) * eff_hop + eff_plen;
      j0  = $urandom_range(lim - 1) - cur_start;
      if (j0 < 0) j0 = $urandom_range(15);
      span = 160 / (eff_plen / eff_hop + 1);
      if (span > 24) span = 24;
      if (span < 1) span = 1;

      for (int n = 0; n < 48 && items_sent < ITEM_TARGET; n++) begin
        if (items_sent >= HOLD_AT && !hold_req) hold_req <= 1'b1;
        pick = $urandom_range(99);
        if (pick < 70) query(j0 + $urandom_range(span - 1));
        else if (pick < 80) query($urandom_range(65535));
        else if (pick < 86) query(cur_count + $urandom_range(3));
        else if (pick < 93)
          load_sample($urandom_range(eff_np - 1), $urandom_range(eff_plen - 1));
        else load_sample($urandom_range(MAX_PATCHES - 1), $urandom_range(MAX_PATCH_LEN - 1));
      end
      phase++;
    end

    drain();
    if (fail_count == 0 && pending == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
